// ===== rtl/first_fit_block_allocator_top_macros.svh =====
// assertion macros shared by the checker
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH
// implication checked on every clock edge outside reset
`define FFBA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define FFBA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== rtl/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// shared status codes and request layout for the first-fit allocator
// ----------------------------------------------------------------------------
package ffba_pkg;
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NO_FIT    = 3'd1;
   localparam logic [2:0] ST_USED_FULL = 3'd2;
   localparam logic [2:0] ST_NOT_LIVE  = 3'd3;
   localparam logic [2:0] ST_FREE_FULL = 3'd4;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   localparam logic REG_REGION_START  = 1'b0;
   localparam logic REG_REGION_LENGTH = 1'b1;

   localparam int GRAIN = 8;
endpackage

// ===== rtl/ffba_ram.sv =====
// ----------------------------------------------------------------------------
// ffba_ram
// single-port-write, single-port-read synchronous ram, registered read
// ----------------------------------------------------------------------------
module ffba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== rtl/first_fit_block_allocator_top.sv =====
// one request is in flight at a time: the next request is taken only once the response
// has been accepted and the block is idle again. each scan step reads one ram entry and
// waits for its registered read data, so the fill counts set how long a request takes.
// reset (synchronous, active high) clears the counters and seeding; ram contents, live
// flags included, are kept and only entries below the counts are read.
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// first-fit allocator over a free table and an append-only used table in ram
// ----------------------------------------------------------------------------
module first_fit_block_allocator_top #(
   parameter int FREE_ENTRIES = 256,
   parameter int USED_ENTRIES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // request_size[31:0], block_address[63:32], zero
   input  logic        req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // granted_address[31:0], status[34:32], zero
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wr_data
);
   localparam int FAW = $clog2(FREE_ENTRIES);
   localparam int UAW = $clog2(USED_ENTRIES);
   localparam int FCW = $clog2(FREE_ENTRIES + 1);
   localparam int UCW = $clog2(USED_ENTRIES + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_ARD   = 4'd1;
   localparam logic [3:0] S_ACHK  = 4'd2;
   localparam logic [3:0] S_URD   = 4'd3;
   localparam logic [3:0] S_UCHK  = 4'd4;
   localparam logic [3:0] S_FRD   = 4'd5;
   localparam logic [3:0] S_FCHK  = 4'd6;
   localparam logic [3:0] S_DONE  = 4'd7;

   logic [3:0]  state_ff, state_in;
   logic [31:0] region_start_ff, region_length_ff;
   logic        seeded_ff, seeded_in;
   logic [FCW-1:0] free_cnt_ff, free_cnt_in;
   logic [UCW-1:0] used_cnt_ff, used_cnt_in;
   logic [32:0] size_ff, size_in;
   logic [31:0] addr_ff, addr_in;
   logic [UCW-1:0] ui_ff, ui_in;
   logic [FCW-1:0] fi_ff, fi_in;
   logic [31:0] bstart_ff, bstart_in, bsize_ff, bsize_in;
   logic [UAW-1:0] hit_ff, hit_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] grant_ff, grant_in;
   logic [2:0]  status_ff, status_in;

   logic           f_we, u_we;
   logic [FAW-1:0] f_wa, f_ra;
   logic [UAW-1:0] u_wa, u_ra;
   logic [63:0]    f_wd, f_rd;
   logic [64:0]    u_wd, u_rd;

   ffba_ram #(.WIDTH(64), .DEPTH(FREE_ENTRIES)) u_free_ram (
      .clock(clock), .wr_en(f_we), .wr_addr(f_wa), .wr_data(f_wd),
      .rd_addr(f_ra), .rd_data(f_rd));
   // used entries carry their live flag in the top bit
   ffba_ram #(.WIDTH(65), .DEPTH(USED_ENTRIES)) u_used_ram (
      .clock(clock), .wr_en(u_we), .wr_addr(u_wa), .wr_data(u_wd),
      .rd_addr(u_ra), .rd_data(u_rd));

   logic [32:0] round_sz;
   logic [31:0] req_size, req_addr;
   assign req_size = req_tdata[31:0];
   assign req_addr = req_tdata[63:32];
   assign round_sz = {1'b0, req_size} + 33'(req_size[2:0] != 3'd0 ? 4'd8 - {1'b0, req_size[2:0]}
                                                                   : 4'd0);

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, status_ff, grant_ff};

   logic [31:0] f_start, f_size, u_start, u_size;
   logic        u_live;
   assign f_start = f_rd[31:0];
   assign f_size  = f_rd[63:32];
   assign u_start = u_rd[31:0];
   assign u_size  = u_rd[63:32];
   assign u_live  = u_rd[64];

   always_comb begin
      state_in = state_ff; seeded_in = seeded_ff;
      free_cnt_in = free_cnt_ff; used_cnt_in = used_cnt_ff;
      size_in = size_ff; addr_in = addr_ff;
      ui_in = ui_ff; fi_in = fi_ff; bstart_in = bstart_ff; bsize_in = bsize_ff;
      hit_in = hit_ff; rsp_valid_in = rsp_valid_ff;
      grant_in = grant_ff; status_in = status_ff;
      f_we = 1'b0; f_wa = fi_ff[FAW-1:0]; f_wd = 64'd0; f_ra = fi_ff[FAW-1:0];
      u_we = 1'b0; u_wa = used_cnt_ff[UAW-1:0]; u_wd = 65'd0; u_ra = ui_ff[UAW-1:0];
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               size_in = round_sz; addr_in = req_addr;
               fi_in = '0; ui_in = '0;
               if (req_tuser == ffba_pkg::ACT_ALLOC) begin
                  if (!seeded_ff) begin
                     // seed entry zero with the whole region
                     f_we = 1'b1; f_wa = '0; f_wd = {region_length_ff, region_start_ff};
                     free_cnt_in = FCW'(1); seeded_in = 1'b1;
                  end
                  state_in = round_sz[32] ? S_DONE : S_ARD;
                  status_in = ffba_pkg::ST_NO_FIT;
               end else begin
                  state_in = S_URD;
                  status_in = ffba_pkg::ST_NOT_LIVE;
               end
               grant_in = '0;
            end
         end
         S_ARD: begin
            if (fi_ff >= free_cnt_ff) begin
               state_in = S_DONE;
            end else begin
               f_ra = fi_ff[FAW-1:0];
               state_in = S_ACHK;
            end
         end
         S_ACHK: begin
            // free entries below the count are never retired, so all are live
            if ({1'b0, f_size} >= size_ff) begin
               state_in = S_DONE;
               if (used_cnt_ff >= UCW'(USED_ENTRIES)) begin
                  status_in = ffba_pkg::ST_USED_FULL;
               end else begin
                  f_we = 1'b1; f_wa = fi_ff[FAW-1:0];
                  f_wd = {f_size - size_ff[31:0], f_start + size_ff[31:0]};
                  u_we = 1'b1; u_wa = used_cnt_ff[UAW-1:0];
                  u_wd = {1'b1, size_ff[31:0], f_start};
                  used_cnt_in = used_cnt_ff + UCW'(1);
                  grant_in = f_start; status_in = ffba_pkg::ST_OK;
               end
            end else begin
               fi_in = fi_ff + FCW'(1);
               state_in = S_ARD;
            end
         end
         S_URD: begin
            if (ui_ff >= used_cnt_ff) begin
               state_in = S_DONE;
            end else begin
               u_ra = ui_ff[UAW-1:0];
               state_in = S_UCHK;
            end
         end
         S_UCHK: begin
            if (u_live && u_start == addr_ff) begin
               hit_in = ui_ff[UAW-1:0]; bstart_in = u_start; bsize_in = u_size;
               state_in = S_FRD;
            end else begin
               ui_in = ui_ff + UCW'(1);
               state_in = S_URD;
            end
         end
         S_FRD: begin
            if (fi_ff >= free_cnt_ff) begin
               state_in = S_DONE;
               if (free_cnt_ff >= FCW'(FREE_ENTRIES)) begin
                  status_in = ffba_pkg::ST_FREE_FULL;
               end else begin
                  f_we = 1'b1; f_wa = free_cnt_ff[FAW-1:0]; f_wd = {bsize_ff, bstart_ff};
                  free_cnt_in = free_cnt_ff + FCW'(1);
                  u_we = 1'b1; u_wa = hit_ff; u_wd = {1'b0, bsize_ff, bstart_ff};
                  status_in = ffba_pkg::ST_OK;
               end
            end else begin
               f_ra = fi_ff[FAW-1:0];
               state_in = S_FCHK;
            end
         end
         S_FCHK: begin
            if (f_start == bstart_ff + bsize_ff) begin
               f_we = 1'b1; f_wa = fi_ff[FAW-1:0]; f_wd = {f_size + bsize_ff, bstart_ff};
               u_we = 1'b1; u_wa = hit_ff; u_wd = {1'b0, bsize_ff, bstart_ff};
               status_in = ffba_pkg::ST_OK;
               state_in = S_DONE;
            end else begin
               fi_in = fi_ff + FCW'(1);
               state_in = S_FRD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; seeded_ff <= 1'b0;
         free_cnt_ff <= '0; used_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         region_start_ff <= '0; region_length_ff <= '0;
      end else begin
         state_ff <= state_in; seeded_ff <= seeded_in;
         free_cnt_ff <= free_cnt_in; used_cnt_ff <= used_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            if (csr_index == ffba_pkg::REG_REGION_START) region_start_ff <= csr_wr_data;
            else region_length_ff <= csr_wr_data;
         end
      end
      size_ff <= size_in; addr_ff <= addr_in;
      ui_ff <= ui_in; fi_ff <= fi_in; bstart_ff <= bstart_in; bsize_ff <= bsize_in;
      hit_ff <= hit_in; grant_ff <= grant_in; status_ff <= status_in;
   end
endmodule

// ===== rtl/ffba_checker.sv =====
// ----------------------------------------------------------------------------
// ffba_checker
// port-level checks on the allocator's request and response channels
// ----------------------------------------------------------------------------
`include "first_fit_block_allocator_top_macros.svh"
module ffba_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   `FFBA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "response dropped while stalled")
   `FFBA_ASSERT_IMP(a_no_accept_busy, clock, reset, rsp_tvalid, !req_tready,
      "request taken while response pending")
   `FFBA_ASSERT_IMP(a_status_range, clock, reset, rsp_tvalid,
      rsp_tdata[34:32] <= ffba_pkg::ST_FREE_FULL, "status code out of range")
   `FFBA_ASSERT_IMP(a_grant_zero, clock, reset,
      rsp_tvalid && rsp_tdata[34:32] != ffba_pkg::ST_OK, rsp_tdata[31:0] == 32'd0,
      "nonzero grant on error")
   `FFBA_ASSERT_NXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready,
      !req_tready, "ready stayed high after accept")
endmodule

bind first_fit_block_allocator_top ffba_checker u_ffba_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));
